@@ sv/cmda_pkg.sv @@
// ----------------------------------------------------------------------------
// cmda_pkg
// shared types and constants for the circular medoid angle block
// ----------------------------------------------------------------------------
package cmda_pkg;

  localparam int MAX_SAMPLES = 32;

  localparam int ANGLE_W   = 9;
  localparam int CFG_W     = 6;
  localparam int SUM_OUT_W = 13;
  localparam int USED_W    = 6;
  localparam int DIST_W    = 8;

  localparam int HALF_TURN = 180;
  localparam int FULL_TURN = 360;
  localparam int SUM_SAT   = 8191;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = $clog2(MAX_SAMPLES * HALF_TURN + 1);
  localparam int CNTX_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SUMX_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

  localparam int          ADDR_W          = 3;
  localparam logic [2:0]  REG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_W-1:0] SAMPLE_COUNT_RST = CFG_W'(24);

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]   dominant_angle;
    logic [SUM_OUT_W-1:0] distance_sum;
    logic [USED_W-1:0]    samples_used;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PREP,
    ST_SCORE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREP,
    CELL_SCORE,
    CELL_DRAIN
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] size;
  } chain_ctrl_t;

  function automatic logic [DIST_W-1:0] circ_dist(input logic [ANGLE_W-1:0] a,
                                                  input logic [ANGLE_W-1:0] b);
    logic [ANGLE_W-1:0] d;
    logic [ANGLE_W-1:0] w;
    d = (a > b) ? (a - b) : (b - a);
    w = (d > ANGLE_W'(HALF_TURN)) ? (ANGLE_W'(FULL_TURN) - d) : d;
    return w[DIST_W-1:0];
  endfunction

endpackage

@@ sv/circular_medoid_angle_top.sv @@
// ----------------------------------------------------------------------------
// circular_medoid_angle_top
// circular medoid of a set of compass angles over a chain of cells
// ----------------------------------------------------------------------------
// items on the in_ channel carry an angle in degrees and a last flag; a set
// closes on last or when the sample_count register is reached
// each accepted angle shifts into the head of the cell row, one per cycle while in_stall is low
// when a set of n angles closes, in_stall goes high for the scoring pass:
//   a prep step, a score phase in which the angles circulate round the ring of
//   n cells while every cell adds up its distances, then a drain phase moving
//   the sums past the minimum search at the head of the row
// the result sits in an output register; the next set is taken in while it
// waits, and a finished search holds (in_stall high) while an earlier result
// is still pending and out_stall is high
// sample_count is to be written over the APB port only while the block is
// idle; the block itself does not enforce this
// after reset: empty set, sample_count 24, no result pending
// ----------------------------------------------------------------------------
module circular_medoid_angle_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cmda_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cmda_pkg::out_item_t                out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cmda_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int CNT_W  = cmda_pkg::CNT_W;
  localparam int CNTX_W = cmda_pkg::CNTX_W;
  localparam int SUM_W  = cmda_pkg::SUM_W;
  localparam int SUMX_W = cmda_pkg::SUMX_W;
  localparam int AW     = cmda_pkg::ANGLE_W;

  cmda_pkg::state_t state_r, state_nxt;

  logic [cmda_pkg::CFG_W-1:0] sample_count_r;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic [CNT_W-1:0]           size_r, size_nxt;
  logic [CNT_W-1:0]           step_r, step_nxt;
  logic [AW-1:0]              best_angle_r, best_angle_nxt;
  logic [SUM_W-1:0]           best_sum_r, best_sum_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cmda_pkg::out_item_t        out_data_r, out_data_nxt;

  cmda_pkg::chain_ctrl_t      ctrl;
  logic [AW-1:0]              new_angle;
  logic [AW-1:0]              head_angle;
  logic [SUM_W-1:0]           head_sum;

  logic                       accept;
  logic                       cfg_write;
  logic [CNTX_W-1:0]          cfg_x;
  logic [CNTX_W-1:0]          limit;
  logic [CNTX_W-1:0]          fill_inc;
  logic                       closes;
  logic [SUMX_W-1:0]          best_x;
  logic [CNTX_W-1:0]          size_x;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= cmda_pkg::SAMPLE_COUNT_RST;
    end else if (cfg_write && paddr == cmda_pkg::REG_SAMPLE_COUNT) begin
      sample_count_r <= pwdata[cmda_pkg::CFG_W-1:0];
    end
  end

  assign prdata = (paddr == cmda_pkg::REG_SAMPLE_COUNT) ? 32'(sample_count_r) : '0;

  // set closing
  assign in_stall = (state_r != cmda_pkg::ST_COLLECT);
  assign accept   = in_valid && !in_stall;
  assign new_angle = (in_data.angle > AW'(cmda_pkg::FULL_TURN))
                     ? (in_data.angle - AW'(cmda_pkg::FULL_TURN)) : in_data.angle;

  assign cfg_x    = CNTX_W'(sample_count_r);
  assign limit    = (cfg_x == '0) ? CNTX_W'(1)
                  : (cfg_x > CNTX_W'(cmda_pkg::MAX_SAMPLES)) ? CNTX_W'(cmda_pkg::MAX_SAMPLES)
                  : cfg_x;
  assign fill_inc = CNTX_W'(fill_r) + CNTX_W'(1);
  assign closes   = in_data.last || (fill_inc >= limit);

  assign best_x = SUMX_W'(best_sum_r);
  assign size_x = CNTX_W'(size_r);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    size_nxt       = size_r;
    step_nxt       = step_r;
    best_angle_nxt = best_angle_r;
    best_sum_nxt   = best_sum_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ctrl.op        = cmda_pkg::CELL_HOLD;
    ctrl.size      = size_r;
    unique case (state_r)
      cmda_pkg::ST_COLLECT: begin
        if (accept) begin
          ctrl.op = cmda_pkg::CELL_LOAD;
          if (closes) begin
            fill_nxt  = '0;
            size_nxt  = CNT_W'(fill_inc);
            state_nxt = cmda_pkg::ST_PREP;
          end else begin
            fill_nxt = CNT_W'(fill_inc);
          end
        end
      end
      cmda_pkg::ST_PREP: begin
        ctrl.op   = cmda_pkg::CELL_PREP;
        step_nxt  = '0;
        state_nxt = cmda_pkg::ST_SCORE;
      end
      cmda_pkg::ST_SCORE: begin
        ctrl.op  = cmda_pkg::CELL_SCORE;
        step_nxt = step_r + CNT_W'(1);
        if (step_r == size_r - CNT_W'(1)) begin
          step_nxt  = '0;
          state_nxt = cmda_pkg::ST_DRAIN;
        end
      end
      cmda_pkg::ST_DRAIN: begin
        // sums leave latest first, so an equal sum later on is the earlier angle
        ctrl.op  = cmda_pkg::CELL_DRAIN;
        step_nxt = step_r + CNT_W'(1);
        if (step_r == '0 || head_sum <= best_sum_r) begin
          best_angle_nxt = head_angle;
          best_sum_nxt   = head_sum;
        end
        if (step_r == size_r - CNT_W'(1)) begin
          state_nxt = cmda_pkg::ST_DONE;
        end
      end
      cmda_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.dominant_angle = best_angle_r;
          out_data_nxt.distance_sum   = (best_x > SUMX_W'(cmda_pkg::SUM_SAT))
                                        ? cmda_pkg::SUM_OUT_W'(cmda_pkg::SUM_SAT)
                                        : best_x[cmda_pkg::SUM_OUT_W-1:0];
          out_data_nxt.samples_used   = size_x[cmda_pkg::USED_W-1:0];
          state_nxt                    = cmda_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_nxt = cmda_pkg::ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmda_pkg::ST_COLLECT;
      fill_r      <= '0;
      size_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      size_r      <= size_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_angle_r <= best_angle_nxt;
    best_sum_r   <= best_sum_nxt;
    out_data_r   <= out_data_nxt;
  end

  cmda_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .new_angle  (new_angle),
    .head_angle (head_angle),
    .head_sum   (head_sum)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(cmda_pkg::MAX_SAMPLES))
    else $error("fill count beyond the cell row");

  a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != cmda_pkg::ST_COLLECT |-> fill_r == '0)
    else $error("open set not empty during scoring");

  a_size_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != cmda_pkg::ST_COLLECT |-> size_r != '0 && size_r <= CNT_W'(cmda_pkg::MAX_SAMPLES))
    else $error("set size out of range while scoring");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cmda_pkg::ST_SCORE || state_r == cmda_pkg::ST_DRAIN) |-> step_r < size_r)
    else $error("step counter past the set");

  a_close_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cmda_pkg::ST_DONE && !(out_valid_r && out_stall) |=> out_valid_r)
    else $error("finished search did not reach the output");

endmodule

@@ sv/cmda_cell.sv @@
// ----------------------------------------------------------------------------
// cmda_cell
// one cell: holds an angle, a circulating angle and a running distance sum
// ----------------------------------------------------------------------------
module cmda_cell (
  input  logic                            clk,
  input  cmda_pkg::cell_op_t              op,
  input  logic                            active,
  input  logic [cmda_pkg::ANGLE_W-1:0]    load_angle,
  input  logic [cmda_pkg::ANGLE_W-1:0]    ring_angle,
  input  logic [cmda_pkg::ANGLE_W-1:0]    drain_angle,
  input  logic [cmda_pkg::SUM_W-1:0]      drain_sum,
  output logic [cmda_pkg::ANGLE_W-1:0]    angle_o,
  output logic [cmda_pkg::ANGLE_W-1:0]    circ_o,
  output logic [cmda_pkg::SUM_W-1:0]      sum_o
);

  logic [cmda_pkg::ANGLE_W-1:0] angle_r, angle_nxt;
  logic [cmda_pkg::ANGLE_W-1:0] circ_r, circ_nxt;
  logic [cmda_pkg::SUM_W-1:0]   sum_r, sum_nxt;

  always_comb begin
    angle_nxt = angle_r;
    circ_nxt  = circ_r;
    sum_nxt   = sum_r;
    unique case (op)
      cmda_pkg::CELL_HOLD: begin
      end
      cmda_pkg::CELL_LOAD: begin
        angle_nxt = load_angle;
      end
      cmda_pkg::CELL_PREP: begin
        circ_nxt = angle_r;
        sum_nxt  = '0;
      end
      cmda_pkg::CELL_SCORE: begin
        circ_nxt = ring_angle;
        if (active) begin
          sum_nxt = sum_r + cmda_pkg::SUM_W'(cmda_pkg::circ_dist(angle_r, circ_r));
        end
      end
      cmda_pkg::CELL_DRAIN: begin
        angle_nxt = drain_angle;
        sum_nxt   = drain_sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
    circ_r  <= circ_nxt;
    sum_r   <= sum_nxt;
  end

  assign angle_o = angle_r;
  assign circ_o  = circ_r;
  assign sum_o   = sum_r;

endmodule

@@ sv/cmda_chain.sv @@
// ----------------------------------------------------------------------------
// cmda_chain
// row of cells: angles shift in, circulate round a ring of set size, drain out
// ----------------------------------------------------------------------------
module cmda_chain (
  input  logic                            clk,
  input  cmda_pkg::chain_ctrl_t           ctrl,
  input  logic [cmda_pkg::ANGLE_W-1:0]    new_angle,
  output logic [cmda_pkg::ANGLE_W-1:0]    head_angle,
  output logic [cmda_pkg::SUM_W-1:0]      head_sum
);

  localparam int N = cmda_pkg::MAX_SAMPLES;

  logic [cmda_pkg::ANGLE_W-1:0] angle_w [N];
  logic [cmda_pkg::ANGLE_W-1:0] circ_w  [N];
  logic [cmda_pkg::SUM_W-1:0]   sum_w   [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [cmda_pkg::ANGLE_W-1:0] load_a;
    logic [cmda_pkg::ANGLE_W-1:0] ring_a;
    logic [cmda_pkg::ANGLE_W-1:0] drain_a;
    logic [cmda_pkg::SUM_W-1:0]   drain_s;
    logic                         active;

    assign active = (cmda_pkg::CNT_W'(i) < ctrl.size);

    if (i == 0) begin : g_first
      assign load_a = new_angle;
    end else begin : g_mid
      assign load_a = angle_w[i-1];
    end

    if (i == N - 1) begin : g_last
      assign ring_a  = circ_w[0];
      assign drain_a = '0;
      assign drain_s = '0;
    end else begin : g_inner
      // the cell at the end of the set wraps round to the head
      assign ring_a  = (ctrl.size == cmda_pkg::CNT_W'(i + 1)) ? circ_w[0] : circ_w[i+1];
      assign drain_a = angle_w[i+1];
      assign drain_s = sum_w[i+1];
    end

    cmda_cell u_cell (
      .clk         (clk),
      .op          (ctrl.op),
      .active      (active),
      .load_angle  (load_a),
      .ring_angle  (ring_a),
      .drain_angle (drain_a),
      .drain_sum   (drain_s),
      .angle_o     (angle_w[i]),
      .circ_o      (circ_w[i]),
      .sum_o       (sum_w[i])
    );
  end

  assign head_angle = angle_w[0];
  assign head_sum   = sum_w[0];

endmodule
